// ===== sv/hts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants for heading_to_wheel_speeds
// Widths, angle constants, the arctangent table, sequencer states, turn modes
// and the control word that the sequencer hands to the datapath units.
// ----------------------------------------------------------------------------
package hts_pkg;

  // word layout
  localparam int HEAD_W     = 16;  // heading_x, heading_y
  localparam int SPD_W      = 17;  // left_speed, right_speed
  localparam int MODE_W     = 2;   // turn_mode
  localparam int IN_W       = 2 * HEAD_W;
  localparam int OUT_RAW_W  = 2 * SPD_W + MODE_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

  // configuration
  localparam int THR_W      = 14;  // angle thresholds, Q2.12
  localparam int MAXS_W     = 15;  // wheel speed cap, Q7.8
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_TURN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_TURN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_TURN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP = 3'd3;

  // iteration counts
  localparam int ANGLE_ITERATIONS = 16;
  localparam int SQRT_STEPS       = 16;
  localparam int DIV_STEPS        = 16;
  localparam int LOOP_STEPS = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;
  localparam int CNT_W      = $clog2(LOOP_STEPS + 1);

  // vector unit widths
  localparam int SCALE_SH   = 16;  // inputs scaled by 2^16 before rotation
  localparam int XY_W       = 35;
  localparam int Z_W        = 21;
  localparam int ANG_W      = 15;  // Q3.12 angle, signed
  localparam int SQ_W       = 32;
  localparam int LEN_W      = 16;
  localparam int ATAN_W     = 16;
  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = 5;

  localparam int PI_Q16      = 205887;
  localparam int PI_Q12      = 12868;
  localparam int HALF_PI_Q12 = 6434;

  // divider widths
  localparam int PROD_W = MAXS_W + THR_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int QUO_W  = 16;
  localparam int DEN_W  = THR_W + 1;

  // round(atan(2^-i) * 2^16)
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256,   16'd128,   16'd64,    16'd32,   16'd16,   16'd8,    16'd4,    16'd2,
    16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,    16'd0
  };

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    v = '0;
    if (i < ATAN_IDX_W'(ATAN_DEPTH)) begin
      v = ATAN_TAB[i];
    end
    return v;
  endfunction

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_HARD = 2'd2
  } hts_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ITER,
    S_ANGLE,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_FIN
  } hts_state_t;

  typedef struct packed {
    logic             load;      // word accepted: capture heading
    logic             sqrt_load; // start the root from the summed squares
    logic             iter;      // one rotation / root step
    logic [CNT_W-1:0] idx;       // step number
    logic             angle;     // capture angle and base speed
    logic             mul;       // base * |angle|
    logic             div_load;  // set up the divider
    logic             div_step;  // one quotient bit
    logic             finish;    // result written to the output register
  } hts_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/hts_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_seq: sequencer
// Steps one heading word through the rotation/root loop, the angle capture,
// the multiply and the bit-serial divide, then writes the result.
// ----------------------------------------------------------------------------
module hts_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               out_free,
  output logic                    in_ready,
  output hts_pkg::hts_ctrl_t      ctrl
);

  hts_pkg::hts_state_t            state_r, state_nxt;
  logic [hts_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hts_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      hts_pkg::S_IDLE: begin
        if (in_valid) state_nxt = hts_pkg::S_PREP;
      end
      hts_pkg::S_PREP: begin
        state_nxt = hts_pkg::S_ITER;
        cnt_nxt   = '0;
      end
      hts_pkg::S_ITER: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == hts_pkg::CNT_W'(hts_pkg::LOOP_STEPS - 1)) state_nxt = hts_pkg::S_ANGLE;
      end
      hts_pkg::S_ANGLE: state_nxt = hts_pkg::S_MUL;
      hts_pkg::S_MUL:   state_nxt = hts_pkg::S_DLOAD;
      hts_pkg::S_DLOAD: begin
        state_nxt = hts_pkg::S_DIV;
        cnt_nxt   = '0;
      end
      hts_pkg::S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == hts_pkg::CNT_W'(hts_pkg::DIV_STEPS - 1)) state_nxt = hts_pkg::S_FIN;
      end
      hts_pkg::S_FIN: begin
        if (out_free) state_nxt = hts_pkg::S_IDLE;
      end
      default: state_nxt = hts_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    ctrl           = '0;
    ctrl.idx       = cnt_r;
    unique case (state_r)
      hts_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      hts_pkg::S_PREP:  ctrl.sqrt_load = 1'b1;
      hts_pkg::S_ITER:  ctrl.iter      = 1'b1;
      hts_pkg::S_ANGLE: ctrl.angle     = 1'b1;
      hts_pkg::S_MUL:   ctrl.mul       = 1'b1;
      hts_pkg::S_DLOAD: ctrl.div_load  = 1'b1;
      hts_pkg::S_DIV:   ctrl.div_step  = 1'b1;
      hts_pkg::S_FIN:   ctrl.finish    = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/hts_vec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_vec: vector unit
// Vectoring rotation for atan2 (one micro-rotation per step through shifters
// and adders) next to a one-bit-per-step integer square root.
// ----------------------------------------------------------------------------
module hts_vec (
  input  wire logic                             clk,
  input  wire hts_pkg::hts_ctrl_t               ctrl,
  input  wire logic signed [hts_pkg::HEAD_W-1:0] hx,
  input  wire logic signed [hts_pkg::HEAD_W-1:0] hy,
  output logic signed [hts_pkg::ANG_W-1:0]      ang,
  output logic [hts_pkg::LEN_W-1:0]             len
);

  localparam int XY_W = hts_pkg::XY_W;
  localparam int Z_W  = hts_pkg::Z_W;
  localparam int SQ_W = hts_pkg::SQ_W;

  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic                     y0_r, x0_r, xneg_r, ypos_r;
  logic [SQ_W-1:0]          px_r, py_r;
  logic [SQ_W-1:0]          n_r, r_r, bit_r;

  logic signed [XY_W-1:0]   hx_w, hy_w, x_ld, y_ld, dx, dy;
  logic signed [Z_W-1:0]    z_ld, atan_s, zr8, zq;
  logic signed [2*hts_pkg::HEAD_W-1:0] px_s, py_s;
  logic                     cordic_en, sqrt_en;
  logic [SQ_W-1:0]          trial;

  assign cordic_en = ctrl.iter && (ctrl.idx < hts_pkg::CNT_W'(hts_pkg::ANGLE_ITERATIONS));
  assign sqrt_en   = ctrl.iter && (ctrl.idx < hts_pkg::CNT_W'(hts_pkg::SQRT_STEPS));

  // start vector: scaled, folded into the right half plane
  always_comb begin
    hx_w = {{(XY_W-hts_pkg::HEAD_W){hx[hts_pkg::HEAD_W-1]}}, hx} <<< hts_pkg::SCALE_SH;
    hy_w = {{(XY_W-hts_pkg::HEAD_W){hy[hts_pkg::HEAD_W-1]}}, hy} <<< hts_pkg::SCALE_SH;
    px_s = hx * hx;
    py_s = hy * hy;
    if (hx < 0) begin
      x_ld = -hx_w;
      y_ld = -hy_w;
      z_ld = (hy >= 0) ? Z_W'(hts_pkg::PI_Q16) : -Z_W'(hts_pkg::PI_Q16);
    end else begin
      x_ld = hx_w;
      y_ld = hy_w;
      z_ld = '0;
    end
  end

  // micro-rotation terms
  always_comb begin
    dx     = y_r >>> ctrl.idx;
    dy     = x_r >>> ctrl.idx;
    atan_s = {{(Z_W-hts_pkg::ATAN_W){1'b0}},
              hts_pkg::atan_lut(hts_pkg::ATAN_IDX_W'(ctrl.idx))};
  end

  // rotation registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r    <= x_ld;
      y_r    <= y_ld;
      z_r    <= z_ld;
      y0_r   <= (hy == 0);
      x0_r   <= (hx == 0);
      xneg_r <= (hx < 0);
      ypos_r <= (hy > 0);
      px_r   <= SQ_W'(px_s);
      py_r   <= SQ_W'(py_s);
    end else if (cordic_en) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_s;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_s;
      end
    end
  end

  // square root, one result bit per step
  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (ctrl.sqrt_load) begin
      n_r   <= px_r + py_r;
      r_r   <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (sqrt_en) begin
      if (n_r >= trial) begin
        n_r <= n_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign len = r_r[hts_pkg::LEN_W-1:0];

  // round to Q3.12, clamp, and take the exact axes
  always_comb begin
    zr8 = z_r + Z_W'(8);
    zq  = zr8 >>> 4;
    if (zq > Z_W'(hts_pkg::PI_Q12)) begin
      zq = Z_W'(hts_pkg::PI_Q12);
    end else if (zq < -Z_W'(hts_pkg::PI_Q12 - 1)) begin
      zq = -Z_W'(hts_pkg::PI_Q12 - 1);
    end
    if (y0_r) begin
      ang = xneg_r ? hts_pkg::ANG_W'(hts_pkg::PI_Q12) : '0;
    end else if (x0_r) begin
      ang = ypos_r ? hts_pkg::ANG_W'(hts_pkg::HALF_PI_Q12)
                   : -hts_pkg::ANG_W'(hts_pkg::HALF_PI_Q12);
    end else begin
      ang = zq[hts_pkg::ANG_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/hts_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_div: soft-turn speed offset
// Computes (2*base*|angle| + hard) / (2*hard) with one multiply and a
// restoring divider that settles one quotient bit per step.
// ----------------------------------------------------------------------------
module hts_div (
  input  wire logic                         clk,
  input  wire hts_pkg::hts_ctrl_t           ctrl,
  input  wire logic [hts_pkg::MAXS_W-1:0]   base,
  input  wire logic [hts_pkg::THR_W-1:0]    mag,
  input  wire logic [hts_pkg::THR_W-1:0]    hard,
  output logic [hts_pkg::QUO_W-1:0]         quo
);

  localparam int NUM_W = hts_pkg::NUM_W;
  localparam int QUO_W = hts_pkg::QUO_W;
  localparam int DEN_W = hts_pkg::DEN_W;

  logic [hts_pkg::PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]           den_r, rem_r, rem_nxt;
  logic [QUO_W-1:0]           qn_r;
  logic [NUM_W-1:0]           num;
  logic [DEN_W:0]             t;
  logic                       ge;

  assign num = {prod_r, 1'b0} + NUM_W'(hard);

  // trial subtract
  always_comb begin
    t       = {rem_r, qn_r[QUO_W-1]};
    ge      = (t >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(t - {1'b0, den_r}) : DEN_W'(t);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= base * mag;
    end
    if (ctrl.div_load) begin
      den_r <= {hard, 1'b0};
      rem_r <= DEN_W'(num[NUM_W-1:QUO_W]);
      qn_r  <= num[QUO_W-1:0];
    end else if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      qn_r  <= {qn_r[QUO_W-2:0], ge};
    end
  end

  assign quo = qn_r;

endmodule
`default_nettype wire

// ===== sv/heading_to_wheel_speeds.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heading_to_wheel_speeds: differential-drive wheel speeds from a heading
// Turns a Q8.8 heading vector into left/right wheel speeds and a turn mode.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per heading (x, y). in_tready is high only while the
//           block is idle; a word is taken when in_tvalid and in_tready meet.
//   out_* : one word per heading: left, right speeds and the new turn mode.
//   cfg_* : register writes (index, data); always ready. Write only while idle.
// Timing:
//   Once the input word is taken, the block runs a set-up step, 16
//   rotation/root steps, the angle, multiply and divider set-up steps,
//   a 16-step bit-serial divide and the final write to the output register.
//   The divider and the rotation loop make up most of these steps. A new word
//   can be taken from the cycle after the result is written, not before.
//   A result waiting in the output register does not stop the next heading
//   from entering; if the receiver still holds off when the next result is
//   done, the block waits in its last step until the register frees up.
// Reset:
//   rst_n clears the sequencer, the turn mode (no turn), the output valid and
//   all configuration registers to zero.
// ----------------------------------------------------------------------------
module heading_to_wheel_speeds (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input words
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [hts_pkg::IN_W-1:0]         in_tdata,  // heading_x, heading_y
  // result words
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [hts_pkg::OUT_W-1:0]             out_tdata, // left_speed, right_speed,
                                                           // turn_mode, zero pad
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SPD_W = hts_pkg::SPD_W;

  hts_pkg::hts_ctrl_t                     ctrl;
  hts_pkg::hts_mode_t                     mode_r, mode_new_r, mode_nxt;
  logic [hts_pkg::THR_W-1:0]              hard_r, soft_r, none_r;
  logic [hts_pkg::MAXS_W-1:0]             max_r, base_r;
  logic signed [hts_pkg::ANG_W-1:0]       ang, ang_r;
  logic [hts_pkg::LEN_W-1:0]              len;
  logic [hts_pkg::THR_W-1:0]              mag;
  logic [hts_pkg::QUO_W-1:0]              quo;
  logic                                   out_valid_r, out_free;
  logic signed [SPD_W-1:0]                left_r, right_r, s1, s2, base_s, d_s;
  hts_pkg::hts_mode_t                     out_mode_r;
  logic [hts_pkg::MAXS_W-1:0]             d;

  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r <= '0;
      soft_r <= '0;
      none_r <= '0;
      max_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hts_pkg::CFG_HARD_TURN: hard_r <= cfg_data[hts_pkg::THR_W-1:0];
        hts_pkg::CFG_SOFT_TURN: soft_r <= cfg_data[hts_pkg::THR_W-1:0];
        hts_pkg::CFG_NO_TURN:   none_r <= cfg_data[hts_pkg::THR_W-1:0];
        hts_pkg::CFG_SPEED_CAP: max_r  <= cfg_data[hts_pkg::MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  hts_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  hts_vec u_vec (
    .clk  (clk),
    .ctrl (ctrl),
    .hx   (in_tdata[hts_pkg::HEAD_W-1:0]),
    .hy   (in_tdata[hts_pkg::IN_W-1:hts_pkg::HEAD_W]),
    .ang  (ang),
    .len  (len)
  );

  // angle and clamped base speed
  always_ff @(posedge clk) begin
    if (ctrl.angle) begin
      ang_r  <= ang;
      base_r <= (len < hts_pkg::LEN_W'(max_r)) ? hts_pkg::MAXS_W'(len) : max_r;
    end
  end

  assign mag = (ang_r < 0) ? hts_pkg::THR_W'(-ang_r) : hts_pkg::THR_W'(ang_r);

  hts_div u_div (
    .clk  (clk),
    .ctrl (ctrl),
    .base (base_r),
    .mag  (mag),
    .hard (hard_r),
    .quo  (quo)
  );

  // mode cascade: hard -> soft, then soft, then none
  always_comb begin
    mode_nxt = mode_r;
    if (mode_nxt == hts_pkg::MODE_HARD && mag <= soft_r) begin
      mode_nxt = hts_pkg::MODE_SOFT;
    end
    if (mode_nxt == hts_pkg::MODE_SOFT) begin
      if (mag > hard_r)       mode_nxt = hts_pkg::MODE_HARD;
      else if (mag <= none_r) mode_nxt = hts_pkg::MODE_NONE;
    end
    if (mode_nxt == hts_pkg::MODE_NONE) begin
      if (mag > hard_r)      mode_nxt = hts_pkg::MODE_HARD;
      else if (mag > none_r) mode_nxt = hts_pkg::MODE_SOFT;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) mode_new_r <= mode_nxt;
  end

  // speed pair from the new mode
  always_comb begin
    d      = (hard_r == '0) ? base_r
           : ((quo > hts_pkg::QUO_W'(base_r)) ? base_r : hts_pkg::MAXS_W'(quo));
    base_s = SPD_W'(base_r);
    d_s    = SPD_W'(d);
    case (mode_new_r)
      hts_pkg::MODE_NONE: begin
        s1 = base_s;
        s2 = base_s;
      end
      hts_pkg::MODE_SOFT: begin
        s1 = base_s - d_s;
        s2 = base_s + d_s;
      end
      hts_pkg::MODE_HARD: begin
        s1 = -SPD_W'(max_r);
        s2 = SPD_W'(max_r);
      end
      default: begin
        s1 = '0;
        s2 = '0;
      end
    endcase
  end

  // turn mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hts_pkg::MODE_NONE;
    end else if (ctrl.finish) begin
      mode_r <= mode_new_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      left_r     <= (ang_r > 0) ? s1 : s2;
      right_r    <= (ang_r > 0) ? s2 : s1;
      out_mode_r <= mode_new_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hts_pkg::OUT_W - hts_pkg::OUT_RAW_W){1'b0}},
                       out_mode_r, right_r, left_r};

  // no second word taken while one is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a word was accepted");

  // straight running gives equal wheels
  a_none_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_mode_r == hts_pkg::MODE_NONE) |-> (left_r == right_r))
    else $error("no-turn result with unequal wheel speeds");

  // hard turn spins in place
  a_hard_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_mode_r == hts_pkg::MODE_HARD) |-> (SPD_W'(left_r + right_r) == '0))
    else $error("hard-turn result with wheels not opposite");

  // mode moves only when a result is written
  a_mode_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(mode_r)) |-> $past(ctrl.finish))
    else $error("turn mode changed without a result");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !ctrl.finish)
    else $error("result written over a word still waiting");

endmodule
`default_nettype wire
